[rtl/trts_pkg.sv]
// ----------------------------------------------------------------------------
// trts_pkg: shared definitions for the trailing reference trade signal
// Order codes, field widths and fixed-point constants used by the block and
// by its port checker.
// ----------------------------------------------------------------------------
package trts_pkg;

  // Field widths
  localparam int PRICE_W  = 32;
  localparam int GAIN_W   = 11;
  localparam int WEIGHT_W = 24;
  localparam int REF_W    = 48;
  localparam int KIND_W   = 2;

  // Reference level fixed point
  localparam int REF_FRAC_BITS = 16;

  // APB port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(655);

  // Priming ratio: 0.95 * 2^16 = 62259.2, built as 62259 * p + floor(p / 5)
  localparam int                     PRIME_MUL_W = 16;
  localparam logic [PRIME_MUL_W-1:0] PRIME_MUL   = PRIME_MUL_W'(62259);

  // floor(p / 5) = (p * ceil(2^33 / 5)) >> 33, exact for p below 2^31
  localparam int                 RECIP_W = 33;
  localparam logic [RECIP_W-1:0] RECIP_5 = 33'h0_6666_6667;

  // Saturated weight
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

  // Order codes
  typedef enum logic [KIND_W-1:0] {
    KIND_NONE = 2'd0,
    KIND_BUY  = 2'd1,
    KIND_SELL = 2'd2
  } order_kind_t;

endpackage

[rtl/trailing_reference_trade_signal.sv]
// ----------------------------------------------------------------------------
// trailing_reference_trade_signal: trailing reference buy/sell generator
// One price beat in, one order beat out, all sequenced arithmetic on one
// shared 48-bit add/subtract unit under a small sequencer.
// ----------------------------------------------------------------------------
// Each price beat yields exactly one order beat. A missing price (zero or
// negative) goes from acceptance straight to the result load. A valid price
// runs the sequencer: creep direction (S_CSIGN, plus S_CNEG for a price below
// the reference), an 11-step shift-add multiply by step_gain, apply, trigger
// check and the result load; a buy adds a 24-step restoring division for the
// weight, skipped when the weight saturates. The first valid price also runs
// the priming path, a 33-step reciprocal multiply for price / 5, a 16-step
// multiply by 62259 and one add. The shared adder carries every step, so one
// price is in flight at a time; in_ready is high only while the sequencer is
// idle. A finished result waits in the output register without stalling the
// input; the next result then waits in S_DONE until that register is free.
// step_gain sits at byte address 0 of the APB port and should be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module trailing_reference_trade_signal
  import trts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // price channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PRICE_W-1:0]  price,
  // order channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   order_kind,
  output logic [WEIGHT_W-1:0] buy_weight,
  output logic [REF_W-1:0]    reference_out,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREC,
    S_PMUL,
    S_PADD,
    S_CSIGN,
    S_CNEG,
    S_CMUL,
    S_CAPPLY,
    S_CHECK,
    S_WOVF,
    S_WDIV,
    S_BUYUPD,
    S_DONE
  } state_t;

  state_t state;

  // Configuration
  logic [GAIN_W-1:0] step_gain;

  // Trading state
  logic               primed;
  logic               selling;
  logic [REF_W-1:0]   ref_level;
  logic [PRICE_W-1:0] cur_ext;
  logic [PRICE_W-1:0] prev_ext;
  logic [PRICE_W-1:0] older_ext;
  logic [PRICE_W-1:0] last_trade;

  // Working registers
  logic [PRICE_W-2:0] price_r;
  logic [5:0]         cnt;
  logic [REF_W-1:0]   acc;
  logic [REF_W-1:0]   sh;
  logic [WEIGHT_W-2:0] quo;
  logic               up;
  order_kind_t        res_kind;
  logic [WEIGHT_W-1:0] res_weight;

  // Shared add/subtract unit
  logic [REF_W-1:0] alu_a;
  logic [REF_W-1:0] alu_b;
  logic             alu_sub;
  logic [REF_W:0]   alu_sum;
  logic [REF_W-1:0] alu_res;
  logic             alu_cout;

  logic [REF_W-1:0]   pf;
  logic [PRICE_W-1:0] p_ext;
  logic [REF_W-1:0]   div_try;
  logic               price_ok;
  logic [PRICE_W-1:0] sell_nr;
  logic [PRICE_W-1:0] buy_nr;
  logic               cfg_wr;

  assign pf       = {1'b0, price_r, {REF_FRAC_BITS{1'b0}}};
  assign p_ext    = {1'b0, price_r};
  assign div_try  = {acc[REF_W-2:0], sh[REF_W-1]};
  assign price_ok = (price != '0) && !price[PRICE_W-1];

  // New reference after a trade
  assign sell_nr = ((p_ext > last_trade) || (cur_ext > older_ext)) ? cur_ext : older_ext;
  assign buy_nr  = ((p_ext < last_trade) || (cur_ext < older_ext)) ? cur_ext : older_ext;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[ADDR_W-1];
  assign prdata = paddr[ADDR_W-1] ? '0 : DATA_W'(step_gain);

  assign in_ready = (state == S_IDLE);

  // Select operands for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_PREC: begin
        alu_a = acc;
        alu_b = RECIP_5[cnt] ? REF_W'(price_r) : '0;
      end
      S_PMUL: begin
        alu_a = {acc[REF_W-2:0], 1'b0};
        alu_b = PRIME_MUL[cnt[3:0]] ? REF_W'(price_r) : '0;
      end
      S_PADD: begin
        alu_a = acc;
        alu_b = sh;
      end
      S_CSIGN: begin
        alu_a   = pf;
        alu_b   = ref_level;
        alu_sub = 1'b1;
      end
      S_CNEG: begin
        alu_a   = ref_level;
        alu_b   = pf;
        alu_sub = 1'b1;
      end
      S_CMUL: begin
        alu_a = acc;
        alu_b = step_gain[cnt[3:0]] ? sh : '0;
      end
      S_CAPPLY: begin
        alu_a   = ref_level;
        alu_b   = {5'd0, acc[REF_W-1:5]};
        alu_sub = !up;
      end
      S_CHECK: begin
        alu_a   = selling ? ref_level : pf;
        alu_b   = selling ? pf : ref_level;
        alu_sub = 1'b1;
      end
      S_WOVF: begin
        alu_a   = {8'd0, sh[REF_W-1:8]};
        alu_b   = ref_level;
        alu_sub = 1'b1;
      end
      S_WDIV: begin
        alu_a   = div_try;
        alu_b   = ref_level;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum  = {1'b0, alu_a} + {1'b0, alu_b ^ {REF_W{alu_sub}}} + (REF_W+1)'(alu_sub);
  assign alu_res  = alu_sum[REF_W-1:0];
  assign alu_cout = alu_sum[REF_W];

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step_gain  <= GAIN_RESET;
      primed     <= 1'b0;
      selling    <= 1'b1;
      ref_level  <= '0;
      cur_ext    <= '0;
      prev_ext   <= '0;
      older_ext  <= '0;
      last_trade <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        step_gain <= pwdata[GAIN_W-1:0];
      end
      // Drop a taken beat unless a new one loads in the same cycle
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        // Take a price beat
        S_IDLE: begin
          if (in_valid) begin
            price_r    <= price[PRICE_W-2:0];
            res_kind   <= KIND_NONE;
            res_weight <= '0;
            acc        <= '0;
            if (!price_ok) begin
              state <= S_DONE;
            end else if (!primed) begin
              cnt   <= '0;
              state <= S_PREC;
            end else begin
              state <= S_CSIGN;
            end
          end
        end
        // Price times the reciprocal of five, LSB first, shifting down
        S_PREC: begin
          if (cnt == 6'(RECIP_W - 1)) begin
            sh    <= {alu_cout, alu_res[REF_W-1:1]};
            acc   <= '0;
            cnt   <= 6'(PRIME_MUL_W - 1);
            state <= S_PMUL;
          end else begin
            acc <= {alu_cout, alu_res[REF_W-1:1]};
            cnt <= cnt + 6'd1;
          end
        end
        // Multiply price by 62259, MSB first
        S_PMUL: begin
          acc <= alu_res;
          if (cnt == '0) begin
            state <= S_PADD;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        // Add price / 5 and prime the state
        S_PADD: begin
          ref_level  <= alu_res;
          primed     <= 1'b1;
          selling    <= 1'b1;
          cur_ext    <= p_ext;
          prev_ext   <= p_ext;
          older_ext  <= p_ext;
          last_trade <= p_ext;
          state      <= S_CSIGN;
        end
        // Find the creep direction and distance
        S_CSIGN: begin
          acc <= '0;
          cnt <= '0;
          if (alu_cout) begin
            up    <= 1'b1;
            sh    <= alu_res;
            state <= S_CMUL;
          end else begin
            state <= S_CNEG;
          end
        end
        S_CNEG: begin
          up    <= 1'b0;
          sh    <= alu_res;
          state <= S_CMUL;
        end
        // Distance times gain, LSB first, shifting the partial sum down
        S_CMUL: begin
          acc <= {alu_cout, alu_res[REF_W-1:1]};
          if (cnt == 6'(GAIN_W - 1)) begin
            state <= S_CAPPLY;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        // Move the reference by the truncated step
        S_CAPPLY: begin
          ref_level <= alu_res;
          state     <= S_CHECK;
        end
        // Check for a crossing, else track the extreme
        S_CHECK: begin
          if (selling) begin
            if (alu_cout) begin
              ref_level  <= {sell_nr, {REF_FRAC_BITS{1'b0}}};
              older_ext  <= prev_ext;
              prev_ext   <= cur_ext;
              cur_ext    <= p_ext;
              last_trade <= p_ext;
              selling    <= 1'b0;
              res_kind   <= KIND_SELL;
            end else if (p_ext > cur_ext) begin
              cur_ext <= p_ext;
            end
            state <= S_DONE;
          end else begin
            if (alu_cout) begin
              sh    <= alu_res;
              state <= S_WOVF;
            end else begin
              if (p_ext < cur_ext) begin
                cur_ext <= p_ext;
              end
              state <= S_DONE;
            end
          end
        end
        // Saturate when the ratio reaches 256 or the reference is zero
        S_WOVF: begin
          if (alu_cout) begin
            res_weight <= WEIGHT_MAX;
            state      <= S_BUYUPD;
          end else begin
            acc   <= alu_a;
            sh    <= {sh[7:0], 40'd0};
            quo   <= '0;
            cnt   <= 6'(WEIGHT_W - 1);
            state <= S_WDIV;
          end
        end
        // Weight quotient, one bit per cycle
        S_WDIV: begin
          acc <= alu_cout ? alu_res : div_try;
          quo <= {quo[WEIGHT_W-3:0], alu_cout};
          sh  <= {sh[REF_W-2:0], 1'b0};
          if (cnt == '0) begin
            res_weight <= {quo, alu_cout};
            state      <= S_BUYUPD;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        // Rotate history and reset the reference after a buy
        S_BUYUPD: begin
          ref_level  <= {buy_nr, {REF_FRAC_BITS{1'b0}}};
          older_ext  <= prev_ext;
          prev_ext   <= cur_ext;
          cur_ext    <= p_ext;
          last_trade <= p_ext;
          selling    <= 1'b1;
          res_kind   <= KIND_BUY;
          state      <= S_DONE;
        end
        // Load the output register once it is free
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            order_kind    <= res_kind;
            buy_weight    <= res_weight;
            reference_out <= ref_level;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/trts_checker.sv]
// ----------------------------------------------------------------------------
// trts_checker: port checker for the trailing reference trade signal
// Watches the top level's ports and flags order beats and handshakes that
// the sequencer should never produce.
// ----------------------------------------------------------------------------
module trts_checker
  import trts_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [KIND_W-1:0]   order_kind,
  input logic [WEIGHT_W-1:0] buy_weight,
  input logic [REF_W-1:0]    reference_out
);

  // A weight only travels with a buy
  a_weight_only_on_buy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (order_kind != KIND_BUY)) |-> (buy_weight == '0))
    else $error("nonzero weight on a non-buy beat");

  // A sell resets the reference to a whole price
  a_sell_ref_whole: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (order_kind == KIND_SELL)) |-> (reference_out[REF_FRAC_BITS-1:0] == '0))
    else $error("sell beat with fractional reference");

  // One price at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a price is in flight");

  // Hold a stalled order beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(order_kind) && $stable(buy_weight) && $stable(reference_out)))
    else $error("stalled order beat changed");

endmodule

bind trailing_reference_trade_signal trts_checker u_trts_checker (.*);
